// ===== sv/tcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared constants, types and the arctangent table of the tilt filter.
// ----------------------------------------------------------------------------
package tcf_pkg;

  localparam int unsigned AngleLimit = 5898240;
  localparam int unsigned BlendReset = 49152;
  localparam int unsigned GainReset  = 128070;
  localparam int unsigned IncDivisor = 256000000;
  localparam int unsigned IncHalf    = 128000000;
  // ceil(2^60 / 15625): divide by 256000000 as a 14-bit shift then this
  localparam logic [46:0] IncRecip   = 47'd73786976294839;

  localparam logic       OpUpdate = 1'b0;
  localparam logic       OpInit   = 1'b1;

  localparam logic [1:0] RegBlend = 2'd0;
  localparam logic [1:0] RegGain  = 2'd1;

  typedef struct packed {
    logic        start;
    logic [15:0] own;
    logic [15:0] oth_a;
    logic [15:0] oth_b;
  } tilt_req_t;

  function automatic logic [22:0] atan_entry(input logic [4:0] idx);
    logic [22:0] r;
    case (idx)
      5'd0:  r = 23'd2949120;
      5'd1:  r = 23'd1740967;
      5'd2:  r = 23'd919879;
      5'd3:  r = 23'd466945;
      5'd4:  r = 23'd234379;
      5'd5:  r = 23'd117305;
      5'd6:  r = 23'd58666;
      5'd7:  r = 23'd29335;
      5'd8:  r = 23'd14668;
      5'd9:  r = 23'd7334;
      5'd10: r = 23'd3667;
      5'd11: r = 23'd1833;
      5'd12: r = 23'd917;
      5'd13: r = 23'd458;
      5'd14: r = 23'd229;
      5'd15: r = 23'd115;
      5'd16: r = 23'd57;
      5'd17: r = 23'd29;
      5'd18: r = 23'd14;
      5'd19: r = 23'd7;
      5'd20: r = 23'd4;
      5'd21: r = 23'd2;
      5'd22: r = 23'd1;
      default: r = 23'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/tilt_complementary_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilt_complementary_filter
// Complementary tilt filter: one IMU sample in, one blended angle out.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one sample transaction; output
// channel (out_valid_o / out_stall_i) delivers one result transaction.
// Configuration: APB port, blend_weight at 0x0, gyro_gain at 0x4.
// Each sample runs the three tilts one after another on a shared
// square-root/CORDIC unit, then the gyro increment (two multiplies, a
// rounding step and a reciprocal multiply for the divide), the saturating
// sum and the blend; an initialize skips the increment and the sum.
// in_stall_o stays high until the result is taken and drops the cycle
// after. While the receiver stalls the result holds in the output register.
// Reset clears the stored angles and loads the register defaults.
// ----------------------------------------------------------------------------
module tilt_complementary_filter import tcf_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic [1:0]         axis_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] gyro_rate_i,
  input  logic [19:0]        elapsed_us_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] filtered_angle_o,
  output logic signed [23:0] accel_angle_o,
  output logic signed [31:0] gyro_angle_o
);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StTilt = 4'd1;
  localparam logic [3:0] StWait = 4'd2;
  localparam logic [3:0] StMul1 = 4'd3;
  localparam logic [3:0] StMul2 = 4'd4;
  localparam logic [3:0] StDiv  = 4'd5;
  localparam logic [3:0] StSum  = 4'd6;
  localparam logic [3:0] StBl1  = 4'd7;
  localparam logic [3:0] StBl2  = 4'd8;
  localparam logic [3:0] StOut  = 4'd9;
  localparam logic [3:0] StRnd  = 4'd10;

  logic [3:0]         state_q, state_d;
  logic [16:0]        blend_q;
  logic [24:0]        gain_q;
  logic signed [31:0] ang_q [3];
  logic signed [23:0] tilt_q [3];
  logic [1:0]         ti_q, ti_d;
  logic               op_q;
  logic [1:0]         axis_q;
  logic signed [15:0] ax_q, ay_q, az_q, rate_q;
  logic [19:0]        us_q;
  logic [40:0]        m1_q;
  logic [60:0]        mag_q;
  logic [45:0]        nq_q;
  logic [92:0]        acc_q;
  logic [1:0]         pc_q;
  logic               neg_q;
  logic signed [31:0] gyro_q;
  logic signed [48:0] pa_q, pb_q;
  logic signed [31:0] filt_q;
  logic signed [23:0] acc_out_q;

  tilt_req_t          treq;
  logic               tdone;
  logic signed [23:0] tang;
  logic [16:0]        kk;
  logic [32:0]        quo;
  logic signed [34:0] sum;
  logic signed [31:0] sat;
  logic signed [31:0] cur;
  logic signed [34:0] incs;
  logic signed [50:0] bsum;
  logic [60:0]        rnd;
  logic [22:0]        mul_a;
  logic [23:0]        mul_b;
  logic [46:0]        pp;
  logic [92:0]        pp_sh;
  logic               in_acc, cfg_wr;

  assign pready = 1'b1;
  assign prdata = (paddr[2] ? 32'(gain_q) : 32'(blend_q));
  assign cfg_wr = psel && penable && pwrite;
  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    treq.start = (state_q == StTilt);
    case (ti_q)
      2'd0:    begin treq.own = ax_q; treq.oth_a = ay_q; treq.oth_b = az_q; end
      2'd1:    begin treq.own = ay_q; treq.oth_a = ax_q; treq.oth_b = az_q; end
      default: begin treq.own = az_q; treq.oth_a = ax_q; treq.oth_b = ay_q; end
    endcase
  end

  tcf_tilt #(.Steps(CORDIC_STEPS)) u_tilt (
    .clk_i, .rst_ni, .req_i(treq), .done_o(tdone), .angle_o(tang)
  );

  always_comb begin
    kk   = blend_q[16] ? 17'd65536 : blend_q;
    cur  = ang_q[axis_q];
    quo  = acc_q[92:60];
    incs = neg_q ? -$signed({2'b0, quo}) : $signed({2'b0, quo});
    sum  = 35'(cur) + incs;
    if (sum > 35'sd2147483647)       sat = 32'sh7fffffff;
    else if (sum < -35'sd2147483648) sat = 32'sh80000000;
    else                             sat = sum[31:0];
    bsum  = 51'(pa_q) + 51'(pb_q) + 51'sd32768;
    rnd   = mag_q + 61'(IncHalf);
    mul_a = pc_q[1] ? nq_q[45:23] : nq_q[22:0];
    mul_b = pc_q[0] ? IncRecip[46:23] : {1'b0, IncRecip[22:0]};
    pp    = 47'(mul_a) * 47'(mul_b);
    case (pc_q)
      2'd0:    pp_sh = 93'(pp);
      2'd3:    pp_sh = 93'(pp) << 46;
      default: pp_sh = 93'(pp) << 23;
    endcase
    ti_d = ti_q;
    state_d = state_q;
    case (state_q)
      StIdle: if (in_acc) begin state_d = StTilt; ti_d = 2'd0; end
      StTilt: state_d = StWait;
      StWait: if (tdone) begin
        if (ti_q == 2'd2) state_d = op_q ? StBl1 : StMul1;
        else begin ti_d = ti_q + 1'b1; state_d = StTilt; end
      end
      StMul1: state_d = StMul2;
      StMul2: state_d = StRnd;
      StRnd:  state_d = StDiv;
      StDiv:  if (pc_q == 2'd3) state_d = StSum;
      StSum:  state_d = StBl1;
      StBl1:  state_d = StBl2;
      StBl2:  state_d = StOut;
      StOut:  if (!out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      blend_q <= 17'(BlendReset);
      gain_q  <= 25'(GainReset);
      ang_q[0] <= '0; ang_q[1] <= '0; ang_q[2] <= '0;
      ti_q <= '0;
    end else begin
      state_q <= state_d;
      ti_q <= ti_d;
      if (cfg_wr && paddr[2] == RegBlend[0]) blend_q <= pwdata[16:0];
      if (cfg_wr && paddr[2] == RegGain[0])  gain_q  <= pwdata[24:0];
      if (state_q == StBl1 && op_q) begin
        ang_q[0] <= 32'(tilt_q[0]); ang_q[1] <= 32'(tilt_q[1]);
        ang_q[2] <= 32'(tilt_q[2]);
      end
      if (state_q == StSum && axis_q != 2'd3) ang_q[axis_q] <= sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= operation_i; axis_q <= axis_i; ax_q <= accel_x_i; ay_q <= accel_y_i;
      az_q <= accel_z_i; rate_q <= gyro_rate_i; us_q <= elapsed_us_i;
    end
    if (state_q == StWait && tdone) tilt_q[ti_q] <= tang;
    if (state_q == StMul1) begin
      neg_q <= rate_q[15];
      m1_q  <= 41'($unsigned(rate_q[15] ? -rate_q : rate_q)) * 41'(gain_q);
    end
    if (state_q == StMul2) mag_q <= 61'(m1_q) * 61'(us_q);
    if (state_q == StRnd) begin
      nq_q  <= rnd[59:14];
      acc_q <= '0;
      pc_q  <= '0;
    end
    if (state_q == StDiv) begin
      acc_q <= acc_q + pp_sh;
      pc_q  <= pc_q + 1'b1;
    end
    if (state_q == StSum) gyro_q <= sat;
    if (state_q == StBl1) begin
      if (axis_q == 2'd3) begin
        pa_q <= '0; pb_q <= '0; acc_out_q <= '0;
        if (op_q) gyro_q <= '0;
      end else begin
        acc_out_q <= tilt_q[axis_q];
        if (op_q) begin
          gyro_q <= 32'(tilt_q[axis_q]);
          pa_q <= 49'(tilt_q[axis_q]) * $signed({1'b0, 17'd65536 - kk});
        end else begin
          pa_q <= 49'(gyro_q) * $signed({1'b0, 17'd65536 - kk});
        end
        pb_q <= 49'(tilt_q[axis_q]) * $signed({1'b0, kk});
      end
    end
    if (state_q == StBl2) filt_q <= (axis_q == 2'd3) ? 32'sd0 : bsum[47:16];
  end

  assign filtered_angle_o = filt_q;
  assign accel_angle_o    = acc_out_q;
  assign gyro_angle_o     = (axis_q == 2'd3) ? 32'sd0 : gyro_q;

endmodule

// ===== sv/tcf_tilt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcf_tilt
// Integer square root (one bit a cycle) then CORDIC vectoring (one step a
// cycle) giving atan(own / hypot(a, b)) in Q16.16 degrees, clamped.
// ----------------------------------------------------------------------------
module tcf_tilt import tcf_pkg::*; #(
  parameter int unsigned Steps = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tilt_req_t        req_i,
  output logic             done_o,
  output logic signed [23:0] angle_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSqrt = 2'd1;
  localparam logic [1:0] StCord = 2'd2;
  localparam logic [1:0] StDone = 2'd3;
  localparam int unsigned CntW  = 5;
  localparam logic [CntW-1:0] LastStep = CntW'(Steps - 1);

  logic [1:0]             state_q, state_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [31:0]            rem_q, rem_d;
  logic [16:0]            root_q, root_d;
  logic signed [33:0]     x_q, x_d, y_q, y_d;
  logic signed [24:0]     z_q, z_d;
  logic signed [15:0]     own_q, own_d;

  logic signed [31:0]     sa, sb;
  logic [32:0]            sumsq;
  logic [33:0]            trial;
  logic [16:0]            cand;
  logic signed [33:0]     xs, ys;
  logic signed [24:0]     tv;

  always_comb begin
    sa    = $signed(req_i.oth_a) * $signed(req_i.oth_a);
    sb    = $signed(req_i.oth_b) * $signed(req_i.oth_b);
    sumsq = {1'b0, sa} + {1'b0, sb};
    cand  = root_q | (17'd1 << (5'd16 - cnt_q));
    trial = 34'(cand) * 34'(cand);
    xs    = x_q >>> cnt_q;
    ys    = y_q >>> cnt_q;
    tv    = 25'(atan_entry(cnt_q));
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    root_d  = root_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    own_d   = own_q;
    case (state_q)
      StIdle: begin
        if (req_i.start) begin
          rem_d   = sumsq[31:0];
          root_d  = '0;
          cnt_d   = '0;
          own_d   = req_i.own;
          state_d = StSqrt;
        end
      end
      StSqrt: begin
        if ({1'b0, trial} <= {2'b0, rem_q}) root_d = cand;
        if (cnt_q == 5'd16) begin
          x_d     = 34'($signed({3'b0, ((({1'b0, trial} <= {2'b0, rem_q})) ?
                     cand : root_q), 14'd0}));
          y_d     = 34'(own_q) <<< 14;
          z_d     = '0;
          cnt_d   = '0;
          state_d = StCord;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      StCord: begin
        if (x_q == 0 && y_q == 0) begin
          state_d = StDone;
        end else begin
          if (!y_q[33]) begin
            x_d = x_q + ys; y_d = y_q - xs; z_d = z_q + tv;
          end else begin
            x_d = x_q - ys; y_d = y_q + xs; z_d = z_q - tv;
          end
          if (cnt_q == LastStep) state_d = StDone;
          else cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d; rem_q <= rem_d; root_q <= root_d;
    x_q <= x_d; y_q <= y_d; z_q <= z_d; own_q <= own_d;
  end

  assign done_o = (state_q == StDone);
  always_comb begin
    if (z_q > $signed(25'(AngleLimit)))       angle_o = 24'(AngleLimit);
    else if (z_q < -$signed(25'(AngleLimit))) angle_o = -24'(AngleLimit);
    else                                      angle_o = z_q[23:0];
  end

endmodule
